### hdl/skf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter bank package
// Shared constants, widths and the controller state type.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int AXES     = 3;
    localparam int BANKS    = 2;
    localparam int CHANNELS = BANKS * AXES;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int DATA_W   = 32;
    localparam int RAM_W    = 2 * DATA_W;

    // Gain is unsigned Q1.24 with 1.0 = 2^24, so it needs 25 bits.
    localparam int K_W      = 25;
    localparam logic [K_W-1:0] ONE_Q24 = K_W'(1 << 24);

    // Divider: one quotient bit per cycle.
    localparam int DIV_STEPS = K_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DEN_W     = DATA_W + 1;
    localparam int REM_W     = DATA_W + 2;

    // Multiplier: 33-bit signed multiplicand, 25-bit unsigned multiplier, radix 4.
    localparam int MCAND_W    = DATA_W + 1;
    localparam int PROD_W     = MCAND_W + K_W;
    localparam int MUL_DIGITS = (K_W + 1) / 2;
    localparam int MPLR_W     = 2 * MUL_DIGITS;
    localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << 23;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_SECOND = 2'd2;

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd335544;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd1677722;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_ROUND,
        ST_WB,
        ST_OUT
    } skf_state_t;

endpackage

### hdl/scalar_kalman_filter_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter bank
// One-dimensional Kalman smoothing of gyro samples, per bank and axis.
//
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_bank, s_axis, s_sample
// m_        out        m_valid / m_ready      m_estimate
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// m_valid rises once an in-range transfer has passed the load, prep, divide,
// multiply, round, write-back and output states, and the next input can
// transfer after the return to idle. The 25-step gain divider and the
// 13-step radix-4 multipliers each end with a done pulse.
// An out-of-range item goes straight to the output state to raise m_valid.
// One item is in flight at a time; s_ready is high only while idle.
// Reset clears the channel state through per-channel valid bits at once.
// A result held by a low m_ready stalls the block before its return to idle.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_bank import skf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_bank,
    input  logic [1:0]               s_axis,
    input  logic signed [DATA_W-1:0] s_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_estimate,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    skf_state_t state_reg;
    skf_state_t state_next;

    logic [DATA_W-1:0] q_noise_reg;
    logic [DATA_W-1:0] r_first_reg;
    logic [DATA_W-1:0] r_second_reg;

    logic [CHANNELS-1:0]       valid_reg;
    logic                      bank_reg;
    logic [CH_W-1:0]           idx_reg;
    logic signed [DATA_W-1:0]  sample_reg;
    logic signed [DATA_W-1:0]  x_reg;
    logic [DATA_W-1:0]         pp_reg;
    logic signed [DATA_W:0]    diff_reg;
    logic signed [PROD_W-25:0] delta_reg;
    logic [DATA_W-1:0]         pnew_reg;
    logic signed [DATA_W-1:0]  est_reg;
    logic                      m_valid_reg;
    logic signed [DATA_W-1:0]  m_estimate_reg;

    logic            acc_in_range;
    logic [CH_W-1:0] acc_idx;
    logic            ram_re;
    logic            ram_we;
    logic [RAM_W-1:0] ram_rdata;
    logic            div_start;
    logic            div_done;
    logic [K_W-1:0]  div_quot;
    logic [DEN_W-1:0] div_den;
    logic            mul_start;
    logic            mul_est_done;
    logic            mul_cov_done;
    logic signed [PROD_W-1:0] prod_est;
    logic signed [PROD_W-1:0] prod_cov;
    logic            out_load;

    logic [RAM_W-1:0]         cur_state;
    logic [DATA_W:0]          pp_sum;
    logic [DATA_W-1:0]        r_sel;
    logic signed [PROD_W-1:0] est_rsum;
    logic [PROD_W-1:0]        cov_rsum;
    logic signed [DATA_W+2:0] wb_sum;
    logic signed [DATA_W-1:0] wb_est;

    assign acc_in_range = (32'(s_axis) < AXES) && (32'(s_bank) < BANKS);
    assign acc_idx      = CH_W'(32'(s_bank) * AXES + 32'(s_axis));

    // Configuration.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_noise_reg  <= PROCESS_NOISE_RST;
            r_first_reg  <= MEASURE_NOISE_RST;
            r_second_reg <= MEASURE_NOISE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PROCESS_NOISE:  q_noise_reg  <= cfg_data;
                REG_MEASURE_FIRST:  r_first_reg  <= cfg_data;
                REG_MEASURE_SECOND: r_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Controller.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ram_re     = acc_in_range;
                    state_next = acc_in_range ? ST_LOAD : ST_OUT;
                end
            end
            ST_LOAD: state_next = ST_PREP;
            ST_PREP: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_est_done) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: state_next = ST_WB;
            ST_WB: begin
                ram_we     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Datapath.
    // A channel never written since reset reads as zero estimate and covariance.
    assign cur_state = valid_reg[idx_reg] ? ram_rdata : '0;
    assign pp_sum    = {1'b0, cur_state[DATA_W-1:0]} + {1'b0, q_noise_reg};
    assign r_sel     = bank_reg ? r_second_reg : r_first_reg;
    assign div_den   = {1'b0, pp_reg} + {1'b0, r_sel};

    // Adding half minus one before the arithmetic shift rounds negative
    // products to nearest with ties away from zero.
    assign est_rsum = prod_est + (prod_est[PROD_W-1] ? (ROUND_HALF - 1'b1) : ROUND_HALF);
    assign cov_rsum = prod_cov + ROUND_HALF;

    assign wb_sum = (DATA_W+3)'(x_reg) + (DATA_W+3)'(delta_reg);

    always_comb begin
        if (wb_sum[DATA_W+2:DATA_W-1] == '0 || wb_sum[DATA_W+2:DATA_W-1] == '1) begin
            wb_est = wb_sum[DATA_W-1:0];
        end else if (wb_sum[DATA_W+2]) begin
            wb_est = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            wb_est = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bank_reg   <= s_bank;
                    idx_reg    <= acc_idx;
                    sample_reg <= s_sample;
                    est_reg    <= s_sample;
                end
            end
            ST_LOAD: begin
                x_reg  <= cur_state[RAM_W-1:DATA_W];
                pp_reg <= pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];
            end
            ST_PREP: begin
                diff_reg <= (DATA_W+1)'(sample_reg) - (DATA_W+1)'(x_reg);
            end
            ST_ROUND: begin
                delta_reg <= est_rsum[PROD_W-1:24];
                pnew_reg  <= (cov_rsum[PROD_W-1:56] != '0) ? '1 : cov_rsum[55:24];
            end
            ST_WB: begin
                est_reg <= wb_est;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ram_we) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_estimate_reg <= est_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_estimate = m_estimate_reg;

    skf_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (RAM_W),
        .AW    (CH_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata ({wb_est, pnew_reg}),
        .re    (ram_re),
        .raddr (acc_idx),
        .rdata (ram_rdata)
    );

    skf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (pp_reg),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    skf_mul u_mul_est (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (diff_reg),
        .mplier  (div_quot),
        .done    (mul_est_done),
        .prod    (prod_est)
    );

    skf_mul u_mul_cov (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (signed'({1'b0, pp_reg})),
        .mplier  (ONE_Q24 - div_quot),
        .done    (mul_cov_done),
        .prod    (prod_cov)
    );

    // The divider finishes only while the controller waits for it.
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    // The gain never exceeds one.
    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> div_quot <= ONE_Q24)
        else $error("gain above one");

    // Both multipliers start together and must finish together.
    a_mul_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_est_done == mul_cov_done)
        else $error("multipliers out of step");

    // A written channel is marked valid from the next cycle on.
    a_valid_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> valid_reg[$past(idx_reg)])
        else $error("channel not marked valid after write");

    // A new result appears only out of the output state.
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output state");

endmodule

### hdl/skf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel state RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skf_ram #(
    parameter int DEPTH = 6,
    parameter int WIDTH = 64,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/skf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain divider
// Restoring divider giving floor(num * 2^24 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module skf_div import skf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [K_W-1:0]    quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic                 zero_reg;
    logic [K_W-1:0]       q_reg;
    logic [REM_W-1:0]     rem_diff;
    logic                 rem_ge;

    // The numerator never exceeds the denominator, so the quotient fits in
    // 25 bits and the remainder starts as the numerator itself.
    assign rem_diff = rem_reg - REM_W'(den_reg);
    assign rem_ge   = rem_reg >= REM_W'(den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= REM_W'(num);
            den_reg  <= den;
            zero_reg <= (den == '0);
            q_reg    <= '0;
        end else if (busy_reg) begin
            if (rem_ge) begin
                rem_reg <= {rem_diff[REM_W-2:0], 1'b0};
                q_reg   <= {q_reg[K_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[REM_W-2:0], 1'b0};
                q_reg   <= {q_reg[K_W-2:0], 1'b0};
            end
        end
    end

    // A zero denominator means the gain saturates to one.
    assign quot = zero_reg ? ONE_Q24 : q_reg;
    assign done = done_reg;

endmodule

### hdl/skf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiplier
// Radix-4 shift-and-add multiply of a signed value by an unsigned gain.
// ----------------------------------------------------------------------------
module skf_mul import skf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [MCAND_W-1:0] mcand,
    input  logic        [K_W-1:0]     mplier,
    output logic                      done,
    output logic signed [PROD_W-1:0]  prod
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [MUL_CNT_W-1:0]     cnt_reg;
    logic signed [PROD_W-1:0] mcand_reg;
    logic signed [PROD_W-1:0] triple_reg;
    logic [MPLR_W-1:0]        mplier_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] addend;

    always_comb begin
        case (mplier_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = mcand_reg;
            2'd2:    addend = mcand_reg <<< 1;
            2'd3:    addend = triple_reg;
            default: addend = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MUL_DIGITS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // The true product fits in PROD_W bits, so bits shifted off the top of
    // the partial products do not affect the result.
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= PROD_W'(mcand);
            triple_reg <= PROD_W'(mcand) + (PROD_W'(mcand) <<< 1);
            mplier_reg <= MPLR_W'(mplier);
            acc_reg    <= '0;
        end else if (busy_reg) begin
            acc_reg    <= acc_reg + addend;
            mcand_reg  <= mcand_reg <<< 2;
            triple_reg <= triple_reg <<< 2;
            mplier_reg <= mplier_reg >> 2;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule
